// File: hw/rtl/positional_list_insert_delete_core_defines.svh
// assertion macros shared by the checker of the positional list core
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLID_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("positional list core: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLID_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("positional list core: next-cycle check failed");

`endif

// File: hw/rtl/plid_pkg.sv
// shared types and constants of the positional list core
`default_nettype none

package plid_pkg;

  // list capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // request and result field widths
  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int LEN_W      = 7;
  localparam int SLOT_W     = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT  = 3'd0,
    OP_APPEND     = 3'd1,
    OP_INS_POS    = 3'd2,
    OP_REM_FIRST  = 3'd3,
    OP_REM_LAST   = 3'd4,
    OP_REM_POS    = 3'd5,
    OP_DUMP       = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // command broadcast to every storage cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   at;
    logic [IDX_W-1:0]   last_idx;
    logic [BYTE_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/plid_cell.sv
// one storage cell of the list chain, holds a single byte
`default_nettype none

module plid_cell (
  input  wire logic                      clk,
  input  wire logic [plid_pkg::IDX_W-1:0]  cell_idx,
  input  wire plid_pkg::cell_ctrl_t      ctrl,
  input  wire logic [plid_pkg::BYTE_W-1:0] left_data,
  input  wire logic [plid_pkg::BYTE_W-1:0] right_data,
  input  wire logic [plid_pkg::BYTE_W-1:0] head_data,
  output logic [plid_pkg::BYTE_W-1:0]      data
);
  import plid_pkg::*;

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  // pick the next byte from the neighbors or the broadcast value
  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CELL_INSERT: begin
        if (cell_idx > ctrl.at) begin
          data_nxt = left_data;
        end else if (cell_idx == ctrl.at) begin
          data_nxt = ctrl.value;
        end
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctrl.at) begin
          data_nxt = right_data;
        end
      end
      CELL_ROTATE: begin
        if (cell_idx == ctrl.last_idx) begin
          data_nxt = head_data;
        end else if (cell_idx < ctrl.last_idx) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_insert_delete_core.sv
// Bounded ordered byte list with positional insert, delete and dump. The list lives in a
// row of 64 byte cells; insert and delete shift all cells past the target index at once.
// Every request but dump is accepted, then executed while the result register is loaded,
// and gives one result. In a dump of a non-empty list, after accept and setup the chain
// rotates its filled part by one cell per cycle unless the result side stalls, and the
// front cell is sent out, so after the last element the list is back in its original
// order. Backpressure on the result side stalls the block without losing a result; no
// request is taken until every result of the previous one is in the output register.
`default_nettype none

module positional_list_insert_delete_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // operation[2:0], value[10:3], position[18:11], zero pad
  input  wire logic [plid_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status[1:0], length[8:2], element[16:9], slot[22:17], zero pad
  output logic [plid_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import plid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [BYTE_W-1:0]   value_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    dump_idx_r, dump_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;
  logic [BYTE_W-1:0]   out_element_r, out_element_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctrl_t          ctrl;
  logic [BYTE_W-1:0]   cell_data [CAPACITY];

  logic                in_req;
  logic                out_free;
  logic                full;
  logic                empty;
  logic [POS_W-1:0]    count_ext;
  logic [POS_W-1:0]    count_p1;
  logic [POS_W-1:0]    pos_m1;
  logic [CNT_W-1:0]    count_m1;
  status_t             status;

  assign in_req    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign count_ext = POS_W'(count_r);
  assign count_p1  = count_ext + POS_W'(1);
  assign pos_m1    = pos_r - POS_W'(1);
  assign count_m1  = count_r - CNT_W'(1);

  // status of a list request, and the cell command it needs
  always_comb begin
    status         = ST_OK;
    ctrl.cmd       = CELL_HOLD;
    ctrl.at        = '0;
    ctrl.last_idx  = count_m1[IDX_W-1:0];
    ctrl.value     = value_r;
    count_nxt      = count_r;
    if (state_r == S_EXEC) begin
      case (op_r)
        OP_INS_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.cmd = CELL_INSERT;
          end
        end
        OP_APPEND: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.cmd = CELL_INSERT;
            ctrl.at  = count_r[IDX_W-1:0];
          end
        end
        OP_INS_POS: begin
          if ((pos_r == '0) || (pos_r > count_p1)) begin
            status = ST_BADPOS;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.cmd = CELL_INSERT;
            ctrl.at  = pos_m1[IDX_W-1:0];
          end
        end
        OP_REM_FIRST: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.cmd = CELL_REMOVE;
          end
        end
        OP_REM_LAST: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.cmd = CELL_REMOVE;
            ctrl.at  = count_m1[IDX_W-1:0];
          end
        end
        OP_REM_POS: begin
          if ((pos_r == '0) || (pos_r > count_ext)) begin
            status = ST_BADPOS;
          end else begin
            ctrl.cmd = CELL_REMOVE;
            ctrl.at  = pos_m1[IDX_W-1:0];
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
      // apply only when the result register can take the answer
      if (!out_free) begin
        ctrl.cmd = CELL_HOLD;
      end
      if (ctrl.cmd == CELL_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (ctrl.cmd == CELL_REMOVE) begin
        count_nxt = count_m1;
      end
    end else if ((state_r == S_DUMP) && out_free) begin
      ctrl.cmd = CELL_ROTATE;
    end
  end

  // sequencer and result register
  always_comb begin
    state_nxt       = state_r;
    dump_idx_nxt    = dump_idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_length_nxt  = out_length_r;
    out_element_nxt = out_element_r;
    out_slot_nxt    = out_slot_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((op_r == OP_DUMP) && !empty) begin
          state_nxt    = S_DUMP;
          dump_idx_nxt = '0;
        end else if (out_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status;
          out_length_nxt  = LEN_W'(count_nxt);
          out_element_nxt = '0;
          out_slot_nxt    = '0;
          out_last_nxt    = 1'b1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_length_nxt  = LEN_W'(count_r);
          out_element_nxt = cell_data[0];
          out_slot_nxt    = SLOT_W'(dump_idx_r);
          out_last_nxt    = (dump_idx_r == count_m1[IDX_W-1:0]);
          dump_idx_nxt    = dump_idx_r + IDX_W'(1);
          if (dump_idx_r == count_m1[IDX_W-1:0]) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      dump_idx_r    <= '0;
      out_status_r  <= ST_OK;
      out_length_r  <= '0;
      out_element_r <= '0;
      out_slot_r    <= '0;
      out_last_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      dump_idx_r    <= dump_idx_nxt;
      out_status_r  <= out_status_nxt;
      out_length_r  <= out_length_nxt;
      out_element_r <= out_element_nxt;
      out_slot_r    <= out_slot_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_req) begin
      op_r    <= op_t'(in_tdata[OP_W-1:0]);
      value_r <= in_tdata[OP_W +: BYTE_W];
      pos_r   <= in_tdata[OP_W+BYTE_W +: POS_W];
    end
  end

  // chain of storage cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
    logic [BYTE_W-1:0] left_byte;
    logic [BYTE_W-1:0] right_byte;
    if (g == 0) begin : g_head
      assign left_byte = '0;
    end else begin : g_left
      assign left_byte = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_byte = '0;
    end else begin : g_right
      assign right_byte = cell_data[g+1];
    end
    plid_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctrl       (ctrl),
      .left_data  (left_byte),
      .right_data (right_byte),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - STATUS_W - LEN_W - BYTE_W - SLOT_W)'(0),
                       out_slot_r, out_element_r, out_length_r, out_status_r};

endmodule

`default_nettype wire

// File: hw/rtl/plid_checker.sv
// port-level checker for the positional list core, bound to the top level
`default_nettype none

`include "positional_list_insert_delete_core_defines.svh"

module plid_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [plid_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                            out_tlast
);
  import plid_pkg::*;

  logic [STATUS_W-1:0] res_status;
  logic [LEN_W-1:0]    res_length;
  logic                in_req;

  assign res_status = out_tdata[STATUS_W-1:0];
  assign res_length = out_tdata[STATUS_W +: LEN_W];
  assign in_req     = in_tvalid && in_tready;

  // a stalled result holds
  `PLID_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // one request at a time
  `PLID_ASSERT_NXT(a_one_request, in_req, !in_tready)

  // length never exceeds the capacity
  `PLID_ASSERT_IMP(a_len_bound, out_tvalid, res_length <= LEN_W'(CAPACITY))

  // full status only on a full list
  `PLID_ASSERT_IMP(a_full_len, out_tvalid && (res_status == ST_FULL),
    res_length == LEN_W'(CAPACITY))

  // empty status only on an empty list
  `PLID_ASSERT_IMP(a_empty_len, out_tvalid && (res_status == ST_EMPTY),
    res_length == '0)

endmodule

bind positional_list_insert_delete_core plid_checker u_plid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the positional list core: random and directed requests, scored results
`timescale 1ns / 100ps

module testbench;
  import plid_pkg::*;

  // operation code the core leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  position;
    bit                hold;      // wait until no result is outstanding
  } list_request_t;

  typedef struct {
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] element;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } list_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // operation[2:0], value[10:3], position[18:11], zero pad
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status[1:0], length[8:2], element[16:9], slot[22:17], zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  positional_list_insert_delete_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  list_request_t pending_requests [$];
  list_result_t  expected_results [$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   gen_len = 0;        // list length as the stimulus side sees it

  // predicted list contents
  logic [BYTE_W-1:0] list_bytes [CAPACITY];
  int unsigned       list_len = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // shift the tail up and place one byte
  function automatic status_t list_insert(int unsigned at, logic [BYTE_W-1:0] v);
    if (list_len >= CAPACITY) return ST_FULL;
    for (int unsigned i = list_len; i > at; i--) list_bytes[i] = list_bytes[i - 1];
    list_bytes[at] = v;
    list_len++;
    return ST_OK;
  endfunction

  // close the gap left by one byte
  function automatic void list_remove(int unsigned at);
    for (int unsigned i = at; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i + 1];
    list_len--;
  endfunction

  // apply one request to the predicted list and queue the results it gives
  function automatic void predict_list_results(list_request_t req);
    list_result_t res;
    status_t      st;
    st = ST_OK;
    res.element = '0;
    res.slot    = '0;
    res.last    = 1'b1;
    case (req.op)
      OP_INS_FRONT: st = list_insert(0, req.value);
      OP_APPEND:    st = list_insert(list_len, req.value);
      OP_INS_POS: begin
        if (req.position < 1 || req.position > list_len + 1) st = ST_BADPOS;
        else st = list_insert(req.position - 1, req.value);
      end
      OP_REM_FIRST: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_remove(0);
      end
      OP_REM_LAST: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_remove(list_len - 1);
      end
      OP_REM_POS: begin
        if (req.position < 1 || req.position > list_len) st = ST_BADPOS;
        else list_remove(req.position - 1);
      end
      OP_DUMP: begin
        // one result per element, front first
        if (list_len != 0) begin
          for (int unsigned i = 0; i < list_len; i++) begin
            res.status  = ST_OK;
            res.length  = LEN_W'(list_len);
            res.element = list_bytes[i];
            res.slot    = SLOT_W'(i);
            res.last    = (i + 1 == list_len);
            expected_results.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    res.status = st;
    res.length = LEN_W'(list_len);
    expected_results.push_back(res);
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] value,
                               logic [POS_W-1:0] position, bit hold = 1'b0);
    list_request_t req;
    req.op       = op;
    req.value    = value;
    req.position = position;
    req.hold     = hold;
    pending_requests.push_back(req);
    // follow the length so positions can be aimed into range
    case (op)
      OP_INS_FRONT, OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_INS_POS: begin
        if (position >= 1 && position <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      end
      OP_REM_FIRST, OP_REM_LAST: if (gen_len != 0) gen_len--;
      OP_REM_POS: if (position >= 1 && position <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // random request, mostly with in-range positions
  task automatic queue_random(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) op = OP_W'(OP_INS_FRONT + $urandom_range(0, 2));
    else if (roll < ins_pct + rem_pct) op = OP_W'(OP_REM_FIRST + $urandom_range(0, 2));
    else if (roll < 96) op = OP_DUMP;
    else op = OP_UNUSED;
    position = POS_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 80) begin
      if (op == OP_INS_POS) position = POS_W'($urandom_range(1, gen_len + 1));
      else if (op == OP_REM_POS && gen_len != 0) position = POS_W'($urandom_range(1, gen_len));
    end
    queue_request(op, BYTE_W'($urandom_range(0, 255)), position);
  endtask

  task automatic wait_sent();
    while (pending_requests.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  // request driver and result-side backpressure
  always @(posedge clk) begin : drive_requests
    list_request_t req;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
            !(pending_requests[0].hold && (in_tvalid || expected_results.size() != 0))) begin
          req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_DATA_W'({req.position, req.value, req.op});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // predict on each accepted request, score each accepted result
  always @(posedge clk) begin : score_results
    list_request_t req;
    list_result_t  got;
    list_result_t  want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tdata[1:0]);
        got.length  = out_tdata[8:2];
        got.element = out_tdata[16:9];
        got.slot    = out_tdata[22:17];
        got.last    = out_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d length=%0d element=%0d slot=%0d last=%0b",
                   $time, got.status, got.length, got.element, got.slot, got.last);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.length !== want.length ||
              got.element !== want.element || got.slot !== want.slot ||
              got.last !== want.last) begin
            $display("%0t: mismatch expected status=%0d length=%0d element=%0d slot=%0d last=%0b",
                     $time, want.status, want.length, want.element, want.slot, want.last);
            $display("%0t:          actual   status=%0d length=%0d element=%0d slot=%0d last=%0b",
                     $time, got.status, got.length, got.element, got.slot, got.last);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        req.op       = in_tdata[2:0];
        req.value    = in_tdata[10:3];
        req.position = in_tdata[18:11];
        req.hold     = 1'b0;
        predict_list_results(req);
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 38;
    recv_idle_pct = 85;
    // empty-list cases
    queue_request(OP_DUMP, 8'h00, 8'h00);
    queue_request(OP_REM_FIRST, 8'hFF, 8'hFF);
    queue_request(OP_REM_LAST, 8'h00, 8'h00);
    queue_request(OP_REM_POS, 8'h00, 8'h01);
    queue_request(OP_REM_POS, 8'h00, 8'h00);
    queue_request(OP_INS_POS, 8'h11, 8'h00);
    queue_request(OP_INS_POS, 8'h22, 8'h02);
    // build a short list through every insert kind
    queue_request(OP_INS_POS, 8'h00, 8'h01);
    queue_request(OP_INS_FRONT, 8'hFF, 8'h00);
    queue_request(OP_APPEND, 8'hA5, 8'hFF);
    queue_request(OP_INS_POS, 8'h5A, 8'h04);
    queue_request(OP_INS_POS, 8'h3C, 8'h02);
    queue_request(OP_INS_POS, 8'hC3, 8'hFF);
    queue_request(OP_UNUSED, 8'hFF, 8'hFF);
    queue_request(OP_DUMP, 8'h00, 8'h00);
    // removals at both ends and by position
    queue_request(OP_REM_POS, 8'h00, 8'h05);
    queue_request(OP_REM_POS, 8'h00, 8'h05);
    queue_request(OP_REM_FIRST, 8'h00, 8'h00);
    queue_request(OP_REM_LAST, 8'h00, 8'h00);
    queue_request(OP_REM_POS, 8'h00, 8'h01);
    queue_request(OP_DUMP, 8'h00, 8'h00);
    queue_request(OP_REM_POS, 8'h00, 8'hFF);
    repeat (10) queue_random(55, 30);
    wait_sent();

    // sender idles heavily, receiver lightly; fill to capacity
    send_idle_pct = 85;
    recv_idle_pct = 38;
    while (gen_len < CAPACITY) queue_random(100, 0);
    queue_request(OP_INS_FRONT, 8'h01, 8'h00);
    queue_request(OP_APPEND, 8'h02, 8'h00);
    queue_request(OP_INS_POS, 8'h03, 8'h20);
    // position check wins over the full check
    queue_request(OP_INS_POS, 8'h04, 8'h00);
    queue_request(OP_INS_POS, 8'h05, 8'hC8);
    queue_request(OP_DUMP, 8'h00, 8'h00, 1'b1);
    queue_request(OP_REM_POS, 8'h00, 8'h40);
    queue_request(OP_REM_POS, 8'h00, 8'h40);
    repeat (8) queue_random(35, 50);
    wait_sent();

    // no idling, drain first, then shrink toward empty
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_request(OP_DUMP, 8'h00, 8'h00, 1'b1);
    repeat (6) queue_random(30, 60);
    queue_request(OP_DUMP, 8'h00, 8'h00);
    wait_sent();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/plid_pkg.sv
hw/rtl/plid_cell.sv
hw/rtl/positional_list_insert_delete_core.sv
hw/rtl/plid_checker.sv
bench/testbench.sv
